[rtl/core/twfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twfs_pkg
// Shared types, codes and constants for the tension winch fire sequencer.
// ----------------------------------------------------------------------------
package twfs_pkg;

    // Encoder bits taken from the position field, sign-extended
    localparam int POSITION_WIDTH = 24;
    localparam int ENC_FIELD_W    = 24;
    localparam int POS_USED_W     = (POSITION_WIDTH < ENC_FIELD_W) ? POSITION_WIDTH
                                                                   : ENC_FIELD_W;

    // Configuration register widths
    localparam int CFG_POS_W   = 21;
    localparam int CFG_WAIT_W  = 8;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 2;

    // Threshold arithmetic: up to five 21-bit terms, or the position itself
    localparam int THR_W = 24;
    localparam int CMP_W = ((POS_USED_W > THR_W) ? POS_USED_W : THR_W) + 1;

    localparam int DRIVE_W = 11;
    localparam int PHASE_W = 3;
    localparam int FUNC_W  = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_START  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRE_TRAVEL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRE_WAIT   = 2'd3;

    // Register reset values
    localparam logic signed [CFG_POS_W-1:0] HOLD_START_RST  = -21'sd97000;
    localparam logic signed [CFG_POS_W-1:0] HOLD_STEP_RST   = -21'sd25000;
    localparam logic signed [CFG_POS_W-1:0] FIRE_TRAVEL_RST = -21'sd20000;
    localparam logic [CFG_WAIT_W-1:0]       FIRE_WAIT_RST   = 8'd75;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIRE   = 2'd2;

    // Drive levels, per mille
    localparam logic signed [DRIVE_W-1:0] DRIVE_OFF     = 11'sd0;
    localparam logic signed [DRIVE_W-1:0] DRIVE_LOAD    = -11'sd650;
    localparam logic signed [DRIVE_W-1:0] DRIVE_STAGE0  = -11'sd600;
    localparam logic signed [DRIVE_W-1:0] DRIVE_STAGE1  = -11'sd550;
    localparam logic signed [DRIVE_W-1:0] DRIVE_STAGE2  = -11'sd450;
    localparam logic signed [DRIVE_W-1:0] DRIVE_STAGE3  = -11'sd300;
    localparam logic signed [DRIVE_W-1:0] DRIVE_TRIGGER = -11'sd750;

    localparam logic [CFG_WAIT_W-1:0] FIRE_COUNT_MAX = '1;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT    = 3'd0,
        PH_LOAD    = 3'd1,
        PH_INDEX   = 3'd2,
        PH_ARMED   = 3'd3,
        PH_TRIGGER = 3'd4,
        PH_FIRING  = 3'd5,
        PH_RESET   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [FUNC_W-1:0]             func;
        logic signed [ENC_FIELD_W-1:0] enc_position;
        logic                          index_pin;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_permille;
        logic [PHASE_W-1:0]        phase_code;
        logic                      zero_encoder;
    } out_item_t;

    typedef struct packed {
        logic signed [CFG_POS_W-1:0] hold_start;
        logic signed [CFG_POS_W-1:0] hold_step;
        logic signed [CFG_POS_W-1:0] fire_travel;
        logic [CFG_WAIT_W-1:0]       fire_wait_updates;
    } cfg_t;

    typedef struct packed {
        phase_t                    phase;
        logic signed [DRIVE_W-1:0] drive_level;
        logic [CFG_WAIT_W-1:0]     fire_count;
    } seq_state_t;

endpackage

[rtl/core/twfs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twfs_step
// Next-state logic of the sequencer for one registered item: threshold
// compares, phase transitions, drive level and fire counter.
// ----------------------------------------------------------------------------
module twfs_step
(
    input  twfs_pkg::in_item_t   item,
    input  twfs_pkg::cfg_t       cfg,
    input  twfs_pkg::seq_state_t state,
    output twfs_pkg::seq_state_t state_next,
    output logic                 zero_encoder
);
    import twfs_pkg::*;

    logic signed [CMP_W-1:0]   pos;
    logic signed [CMP_W-1:0]   t0;
    logic signed [CMP_W-1:0]   t1;
    logic signed [CMP_W-1:0]   t2;
    logic signed [CMP_W-1:0]   t3;
    logic signed [CMP_W-1:0]   t_fire;
    logic signed [CMP_W-1:0]   step_x;
    logic                      above_t0;
    logic                      above_t1;
    logic                      above_t2;
    logic                      below_t3;
    logic                      below_fire;
    logic                      is_update;
    logic [CFG_WAIT_W-1:0]     count_inc;
    phase_t                    phase_next;
    logic signed [DRIVE_W-1:0] drive_next;
    logic [CFG_WAIT_W-1:0]     fire_count_next;

    // Thresholds at full precision
    assign pos    = CMP_W'(signed'(item.enc_position[POS_USED_W-1:0]));
    assign step_x = CMP_W'(cfg.hold_step);
    assign t0     = CMP_W'(cfg.hold_start);
    assign t1     = t0 + step_x;
    assign t2     = t1 + step_x;
    assign t3     = t2 + step_x;
    assign t_fire = t3 + CMP_W'(cfg.fire_travel);

    assign above_t0   = pos > t0;
    assign above_t1   = pos > t1;
    assign above_t2   = pos > t2;
    assign below_t3   = pos < t3;
    assign below_fire = pos < t_fire;
    assign is_update  = item.func == FUNC_UPDATE;

    // Saturating fire counter
    assign count_inc = (state.fire_count < FIRE_COUNT_MAX) ? state.fire_count + 1'b1
                                                           : state.fire_count;

    assign state_next = '{phase: phase_next, drive_level: drive_next,
                          fire_count: fire_count_next};

    // Next phase
    always_comb
    begin
        phase_next = state.phase;
        if (item.func == FUNC_LOAD)
        begin
            if (state.phase == PH_WAIT)
                phase_next = PH_LOAD;
        end
        else if (item.func == FUNC_FIRE)
        begin
            if (state.phase == PH_ARMED)
                phase_next = PH_TRIGGER;
        end
        else if (is_update)
        begin
            unique case (state.phase)
                PH_LOAD:    if (item.index_pin) phase_next = PH_INDEX;
                PH_INDEX:   if (below_t3) phase_next = PH_ARMED;
                PH_TRIGGER: if (below_fire) phase_next = PH_FIRING;
                PH_FIRING:
                begin
                    if (count_inc >= cfg.fire_wait_updates)
                        phase_next = PH_RESET;
                end
                PH_RESET:   phase_next = PH_WAIT;
                default:    phase_next = state.phase;
            endcase
        end
    end

    // Drive level, fire counter and encoder zero request
    always_comb
    begin
        drive_next      = state.drive_level;
        fire_count_next = state.fire_count;
        zero_encoder    = 1'b0;
        if (is_update)
        begin
            unique case (state.phase)
                PH_LOAD:
                begin
                    drive_next   = DRIVE_LOAD;
                    zero_encoder = item.index_pin;
                end
                PH_INDEX:
                begin
                    // crossing the last threshold arms with the drive off
                    priority if (below_t3) drive_next = DRIVE_OFF;
                    else if (above_t0)     drive_next = DRIVE_STAGE0;
                    else if (above_t1)     drive_next = DRIVE_STAGE1;
                    else if (above_t2)     drive_next = DRIVE_STAGE2;
                    else                   drive_next = state.drive_level;
                end
                PH_ARMED:   drive_next = DRIVE_OFF;
                PH_TRIGGER:
                begin
                    if (below_fire)
                    begin
                        drive_next      = DRIVE_OFF;
                        fire_count_next = '0;
                    end
                    else
                    begin
                        drive_next = DRIVE_TRIGGER;
                    end
                end
                PH_FIRING:
                begin
                    drive_next      = DRIVE_OFF;
                    fire_count_next = count_inc;
                end
                PH_RESET:   drive_next = DRIVE_OFF;
                default:    drive_next = state.drive_level;
            endcase
        end
    end

endmodule

[rtl/core/tension_winch_fire_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tension_winch_fire_sequencer_unit
// Seven-phase winch sequencer: waiting, loading, indexing, armed, trigger,
// firing, reset. One result per item.
// ----------------------------------------------------------------------------
// Each item is taken into an input register, and from there its result
// (drive level, phase and encoder zero request) goes to the result register.
// The block accepts one item per clock and keeps doing so while a result
// waits on the output, as long as the result register empties. The rate is
// set by the single step through the threshold compares and phase logic,
// which also feeds the sequencer state back for the next item.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata
// and take effect on the next item.
// ----------------------------------------------------------------------------
module tension_winch_fire_sequencer_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  twfs_pkg::in_item_t                    in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output twfs_pkg::out_item_t                   out_item,
    input  logic                                  cfg_we,
    input  logic [twfs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [twfs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import twfs_pkg::*;

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    in_item_t   item_reg;
    logic       item_valid_reg;
    out_item_t  result_reg;
    logic       result_valid_reg;
    logic       zero_encoder;
    logic       advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_start        <= HOLD_START_RST;
            cfg_reg.hold_step         <= HOLD_STEP_RST;
            cfg_reg.fire_travel       <= FIRE_TRAVEL_RST;
            cfg_reg.fire_wait_updates <= FIRE_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOLD_START:  cfg_reg.hold_start  <= cfg_wdata[CFG_POS_W-1:0];
                CFG_HOLD_STEP:   cfg_reg.hold_step   <= cfg_wdata[CFG_POS_W-1:0];
                CFG_FIRE_TRAVEL: cfg_reg.fire_travel <= cfg_wdata[CFG_POS_W-1:0];
                CFG_FIRE_WAIT:
                    cfg_reg.fire_wait_updates <= cfg_wdata[CFG_WAIT_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: the registered item moves on when the result slot is free
    assign advance   = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = result_valid_reg;
    assign out_item  = result_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    // Sequencer step
    twfs_step u_step
    (
        .item         (item_reg),
        .cfg          (cfg_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .zero_encoder (zero_encoder)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_WAIT;
            state_reg.drive_level <= DRIVE_OFF;
            state_reg.fire_count  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (out_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.drive_permille <= state_next.drive_level;
            result_reg.phase_code     <= state_next.phase;
            result_reg.zero_encoder   <= zero_encoder;
        end
    end

endmodule

[sim/tension_winch_fire_sequencer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tension_winch_fire_sequencer_unit_test
// Self-checking bench for the winch fire sequencer: a directed walk through
// every phase, register extremes, then random load/index/fire cycles with
// stray requests and noise, all checked transfer by transfer against a
// cycle-free prediction of drive, phase and encoder zero request.
// ----------------------------------------------------------------------------
module tension_winch_fire_sequencer_unit_test;

    import twfs_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam longint POS_MAX      = (longint'(1) << (ENC_FIELD_W - 1)) - 1;
    localparam longint POS_MIN      = -(longint'(1) << (ENC_FIELD_W - 1));
    localparam int     RANDOM_ITEMS = 270;
    localparam int     CYCLE_GUARD  = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_item;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Predicted sequencer state and register copies
    phase_t                      seq_phase = PH_WAIT;
    logic signed [DRIVE_W-1:0]   seq_drive = DRIVE_OFF;
    logic [CFG_WAIT_W-1:0]       seq_fire_count = '0;
    logic signed [CFG_POS_W-1:0] cfg_hold_start = HOLD_START_RST;
    logic signed [CFG_POS_W-1:0] cfg_hold_step = HOLD_STEP_RST;
    logic signed [CFG_POS_W-1:0] cfg_fire_travel = FIRE_TRAVEL_RST;
    logic [CFG_WAIT_W-1:0]       cfg_fire_wait = FIRE_WAIT_RST;

    out_item_t results_due[$];
    out_item_t due_item;

    bit idle_on = 1'b0;
    int stall_left = 0;
    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int settings_used = 1;
    int fire_cycles = 0;

    tension_winch_fire_sequencer_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Threshold k of the indexing ladder, full precision
    function automatic longint threshold(int k);
        return longint'(cfg_hold_start) + longint'(k) * longint'(cfg_hold_step);
    endfunction

    function automatic logic signed [ENC_FIELD_W-1:0] clamp_pos(longint v);
        if (v > POS_MAX)
            v = POS_MAX;
        if (v < POS_MIN)
            v = POS_MIN;
        return v[ENC_FIELD_W-1:0];
    endfunction

    function automatic logic signed [ENC_FIELD_W-1:0] rand_pos();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return clamp_pos(POS_MAX);
        else if (r == 1)
            return clamp_pos(POS_MIN);
        else
            return ENC_FIELD_W'($urandom());
    endfunction

    // Position on, just off, or somewhat off a given point, or a random one
    function automatic logic signed [ENC_FIELD_W-1:0] near(longint t);
        case ($urandom_range(0, 5))
            0: return clamp_pos(t - 1);
            1: return clamp_pos(t);
            2: return clamp_pos(t + 1);
            3: return clamp_pos(t - $urandom_range(2, 3000));
            4: return clamp_pos(t + $urandom_range(2, 3000));
            default: return rand_pos();
        endcase
    endfunction

    function automatic in_item_t make_item(logic [FUNC_W-1:0] f,
                                           logic signed [ENC_FIELD_W-1:0] p, logic pin);
        in_item_t it;
        it.func = f;
        it.enc_position = p;
        it.index_pin = pin;
        return it;
    endfunction

    // Advance the predicted sequencer by one item and queue its result
    task automatic sequence_step(input in_item_t it);
        longint    pos;
        logic      zero;
        out_item_t r;
        pos = longint'($signed(it.enc_position));
        zero = 1'b0;
        case (it.func)
            FUNC_LOAD:
            begin
                if (seq_phase == PH_WAIT)
                    seq_phase = PH_LOAD;
            end
            FUNC_FIRE:
            begin
                if (seq_phase == PH_ARMED)
                    seq_phase = PH_TRIGGER;
            end
            FUNC_UPDATE:
            begin
                case (seq_phase)
                    PH_LOAD:
                    begin
                        seq_drive = DRIVE_LOAD;
                        if (it.index_pin)
                        begin
                            zero = 1'b1;
                            seq_phase = PH_INDEX;
                        end
                    end
                    PH_INDEX:
                    begin
                        if (pos > threshold(0))
                            seq_drive = DRIVE_STAGE0;
                        else if (pos > threshold(1))
                            seq_drive = DRIVE_STAGE1;
                        else if (pos > threshold(2))
                            seq_drive = DRIVE_STAGE2;
                        else if (pos < threshold(3))
                            seq_drive = DRIVE_STAGE3;
                        // the last stage level is dropped at once on arming
                        if (pos < threshold(3))
                        begin
                            seq_drive = DRIVE_OFF;
                            seq_phase = PH_ARMED;
                        end
                    end
                    PH_ARMED:
                        seq_drive = DRIVE_OFF;
                    PH_TRIGGER:
                    begin
                        if (pos < threshold(3) + longint'(cfg_fire_travel))
                        begin
                            seq_drive = DRIVE_OFF;
                            seq_fire_count = '0;
                            seq_phase = PH_FIRING;
                        end
                        else
                            seq_drive = DRIVE_TRIGGER;
                    end
                    PH_FIRING:
                    begin
                        seq_drive = DRIVE_OFF;
                        if (seq_fire_count != FIRE_COUNT_MAX)
                            seq_fire_count = seq_fire_count + 1'b1;
                        if (seq_fire_count >= cfg_fire_wait)
                            seq_phase = PH_RESET;
                    end
                    PH_RESET:
                    begin
                        seq_drive = DRIVE_OFF;
                        seq_phase = PH_WAIT;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.drive_permille = seq_drive;
        r.phase_code = seq_phase;
        r.zero_encoder = zero;
        results_due.push_back(r);
    endtask

    // One input transfer, with an optional idle gap ahead of it
    task automatic send_item(input in_item_t it);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sequence_step(it);
        items_sent++;
    endtask

    // Stop sending and let every pending result drain
    task automatic wait_idle();
        int guard;
        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (results_due.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HOLD_START:  cfg_hold_start = data[CFG_POS_W-1:0];
            CFG_HOLD_STEP:   cfg_hold_step = data[CFG_POS_W-1:0];
            CFG_FIRE_TRAVEL: cfg_fire_travel = data[CFG_POS_W-1:0];
            CFG_FIRE_WAIT:   cfg_fire_wait = data[CFG_WAIT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic program_settings(input logic [CFG_DATA_W-1:0] start_val,
                                    input logic [CFG_DATA_W-1:0] step_val,
                                    input logic [CFG_DATA_W-1:0] travel_val,
                                    input logic [CFG_DATA_W-1:0] wait_word);
        wait_idle();
        write_reg(CFG_HOLD_START, start_val);
        write_reg(CFG_HOLD_STEP, step_val);
        write_reg(CFG_FIRE_TRAVEL, travel_val);
        write_reg(CFG_FIRE_WAIT, wait_word);
        settings_used++;
    endtask

    // Next item of a fire cycle, given the predicted phase, with some stray requests
    function automatic in_item_t next_cycle_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            case ($urandom_range(0, 2))
                0: return make_item(FUNC_LOAD, rand_pos(), rand_bit());
                1: return make_item(FUNC_FIRE, rand_pos(), rand_bit());
                default: return make_item(FUNC_UNUSED, rand_pos(), rand_bit());
            endcase
        end
        case (seq_phase)
            PH_LOAD:
                return make_item(FUNC_UPDATE, rand_pos(), r < 38);
            PH_INDEX:
            begin
                case ($urandom_range(0, 5))
                    0: return make_item(FUNC_UPDATE, near(threshold(0)), rand_bit());
                    1: return make_item(FUNC_UPDATE, near(threshold(1)), rand_bit());
                    2: return make_item(FUNC_UPDATE, near(threshold(2)), rand_bit());
                    3: return make_item(FUNC_UPDATE, near(threshold(3)), rand_bit());
                    4: return make_item(FUNC_UPDATE,
                                        clamp_pos((threshold(2) + threshold(3)) / 2), 1'b0);
                    default: return make_item(FUNC_UPDATE,
                                              clamp_pos(threshold(3) - $urandom_range(1, 2000)),
                                              rand_bit());
                endcase
            end
            PH_ARMED:
            begin
                if (r < 55)
                    return make_item(FUNC_FIRE, rand_pos(), rand_bit());
                return make_item(FUNC_UPDATE, rand_pos(), rand_bit());
            end
            PH_TRIGGER:
            begin
                if (r < 35)
                    return make_item(FUNC_UPDATE,
                                     clamp_pos(threshold(3) + longint'(cfg_fire_travel)
                                               - $urandom_range(1, 500)), 1'b0);
                return make_item(FUNC_UPDATE, near(threshold(3) + longint'(cfg_fire_travel)),
                                 rand_bit());
            end
            default:
                return make_item(FUNC_UPDATE, rand_pos(), rand_bit());
        endcase
    endfunction

    // Load request, then items chosen by phase until back in waiting
    task automatic run_fire_cycle();
        int steps;
        steps = 0;
        send_item(make_item(FUNC_LOAD, rand_pos(), rand_bit()));
        while (seq_phase != PH_WAIT && steps < CYCLE_GUARD)
        begin
            send_item(next_cycle_item());
            steps++;
        end
        fire_cycles++;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_item(make_item(FUNC_W'($urandom_range(0, 3)), rand_pos(), rand_bit()));
    endtask

    // Directed walk through every phase on the reset thresholds
    task automatic test_directed_walk();
        longint release_pos;
        write_reg(CFG_FIRE_WAIT, 21'd2);
        release_pos = threshold(3) + longint'(cfg_fire_travel);
        idle_on = 1'b0;
        send_item(make_item(FUNC_UPDATE, clamp_pos(POS_MAX), 1'b1));
        send_item(make_item(FUNC_UPDATE, clamp_pos(POS_MIN), 1'b0));
        send_item(make_item(FUNC_FIRE, '0, 1'b0));
        send_item(make_item(FUNC_UNUSED, clamp_pos(POS_MAX), 1'b1));
        send_item(make_item(FUNC_LOAD, '0, 1'b0));
        send_item(make_item(FUNC_LOAD, '0, 1'b1));
        send_item(make_item(FUNC_UPDATE, clamp_pos(POS_MIN), 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(POS_MAX), 1'b1));
        // stray fire request while indexing leaves the drive untouched
        send_item(make_item(FUNC_FIRE, '0, 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(threshold(0) + 1), 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(threshold(0)), 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(threshold(1)), 1'b0));
        // between the last two thresholds the drive holds
        send_item(make_item(FUNC_UPDATE, clamp_pos(threshold(2)), 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(threshold(3)), 1'b1));
        send_item(make_item(FUNC_UPDATE, clamp_pos(threshold(3) - 1), 1'b0));
        send_item(make_item(FUNC_LOAD, '0, 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(POS_MAX), 1'b0));
        idle_on = 1'b1;
        send_item(make_item(FUNC_FIRE, '0, 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(release_pos), 1'b0));
        send_item(make_item(FUNC_UPDATE, clamp_pos(release_pos - 1), 1'b1));
        send_item(make_item(FUNC_UPDATE, '0, 1'b0));
        send_item(make_item(FUNC_UNUSED, '0, 1'b0));
        send_item(make_item(FUNC_UPDATE, '0, 1'b0));
        send_item(make_item(FUNC_UPDATE, '0, 1'b0));
        send_item(make_item(FUNC_UPDATE, '0, 1'b0));
    endtask

    // Register extremes, including zero wait and a full 255-update wait
    task automatic test_register_extremes();
        idle_on = 1'b1;
        program_settings(21'h0FFFFF, 21'h100000, 21'h100000, 21'd1);
        repeat (2) run_fire_cycle();
        program_settings(21'h100000, 21'h0FFFFF, 21'h0FFFFF, 21'h1FFF00);
        repeat (2) run_fire_cycle();
        program_settings(21'd0, 21'd0, 21'd0, 21'd255);
        run_fire_cycle();
        program_settings(HOLD_START_RST, HOLD_STEP_RST, FIRE_TRAVEL_RST,
                         CFG_DATA_W'(FIRE_WAIT_RST));
        run_fire_cycle();
    endtask

    // Random settings and cycles, with noise and idle-free stretches
    task automatic test_random_cycles();
        int start_count;
        int cycles;
        int r;
        logic [CFG_DATA_W-1:0] wait_word;
        start_count = items_sent;
        cycles = 0;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if (cycles % 5 == 0)
            begin
                r = $urandom_range(0, 99);
                wait_word = CFG_DATA_W'($urandom());
                if (r < 85)
                    wait_word[CFG_WAIT_W-1:0] = CFG_WAIT_W'($urandom_range(1, 6));
                else if (r < 95)
                    wait_word[CFG_WAIT_W-1:0] = '0;
                else
                    wait_word[CFG_WAIT_W-1:0] = CFG_WAIT_W'($urandom_range(7, 40));
                program_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                 CFG_DATA_W'($urandom()), wait_word);
            end
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 4) == 0)
                send_noise();
            run_fire_cycle();
            cycles++;
        end
    endtask

    // Output side: random stalls
    always @(negedge clk)
    begin
        if (!idle_on)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 20)
        begin
            stall_left = pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result with nothing expected: drive %0d phase %0d zero %0b",
                         $time, out_item.drive_permille, out_item.phase_code,
                         out_item.zero_encoder);
                error_count++;
            end
            else
            begin
                due_item = results_due.pop_front();
                if (out_item.drive_permille !== due_item.drive_permille)
                begin
                    $display("%0t: drive_permille expected %0d got %0d", $time,
                             due_item.drive_permille, out_item.drive_permille);
                    error_count++;
                end
                if (out_item.phase_code !== due_item.phase_code)
                begin
                    $display("%0t: phase_code expected %0d got %0d", $time,
                             due_item.phase_code, out_item.phase_code);
                    error_count++;
                end
                if (out_item.zero_encoder !== due_item.zero_encoder)
                begin
                    $display("%0t: zero_encoder expected %0b got %0b", $time,
                             due_item.zero_encoder, out_item.zero_encoder);
                    error_count++;
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("tension_winch_fire_sequencer_unit_test failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_walk();
        test_register_extremes();
        test_random_cycles();

        wait_idle();
        repeat (10) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
            error_count++;
        end
        $display("Sent %0d items in %0d fire cycles, checked %0d results.",
                 items_sent, fire_cycles, results_checked);
        $display("Wrote %0d registers across %0d settings, %0d errors.",
                 reg_writes, settings_used, error_count);
        if (error_count == 0)
            $display("tension_winch_fire_sequencer_unit_test passed");
        else
            $display("tension_winch_fire_sequencer_unit_test failed");
        $finish;
    end

endmodule

[tension_winch_fire_sequencer_unit.f]
rtl/core/twfs_pkg.sv
rtl/core/twfs_step.sv
rtl/core/tension_winch_fire_sequencer_unit.sv
sim/tension_winch_fire_sequencer_unit_test.sv
